// File: rtl/sgr_enc_pkg.sv
package sgr_enc_pkg;

  localparam int QueueDepth = 2;

  localparam int NumSlots = 24;
  localparam int SlotW    = 5;
  localparam int NumVals  = 6;
  localparam int ValIdxW  = 3;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_256    = 3'd1;
  localparam logic [2:0] MODE_216    = 3'd2;
  localparam logic [2:0] MODE_GRAY   = 3'd3;
  localparam logic [2:0] MODE_TRUE   = 3'd4;

  // Byte slots of the longest sequence; a job enables the ones it needs.
  localparam logic [SlotW-1:0] SLOT_ESC = 5'd0;
  localparam logic [SlotW-1:0] SLOT_LBR = 5'd1;
  localparam logic [SlotW-1:0] SLOT_F3  = 5'd2;
  localparam logic [SlotW-1:0] SLOT_F8  = 5'd3;
  localparam logic [SlotW-1:0] SLOT_FS0 = 5'd4;
  localparam logic [SlotW-1:0] SLOT_F25 = 5'd5;
  localparam logic [SlotW-1:0] SLOT_FS1 = 5'd6;
  localparam logic [SlotW-1:0] SLOT_FV0 = 5'd7;
  localparam logic [SlotW-1:0] SLOT_FS2 = 5'd8;
  localparam logic [SlotW-1:0] SLOT_FV1 = 5'd9;
  localparam logic [SlotW-1:0] SLOT_FS3 = 5'd10;
  localparam logic [SlotW-1:0] SLOT_FV2 = 5'd11;
  localparam logic [SlotW-1:0] SLOT_MID = 5'd12;
  localparam logic [SlotW-1:0] SLOT_B4  = 5'd13;
  localparam logic [SlotW-1:0] SLOT_B8  = 5'd14;
  localparam logic [SlotW-1:0] SLOT_BS0 = 5'd15;
  localparam logic [SlotW-1:0] SLOT_B25 = 5'd16;
  localparam logic [SlotW-1:0] SLOT_BS1 = 5'd17;
  localparam logic [SlotW-1:0] SLOT_BV0 = 5'd18;
  localparam logic [SlotW-1:0] SLOT_BS2 = 5'd19;
  localparam logic [SlotW-1:0] SLOT_BV1 = 5'd20;
  localparam logic [SlotW-1:0] SLOT_BS3 = 5'd21;
  localparam logic [SlotW-1:0] SLOT_BV2 = 5'd22;
  localparam logic [SlotW-1:0] SLOT_END = 5'd23;

  localparam logic [7:0] CHAR_ESC  = 8'h1B;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef struct packed {
    logic [NumSlots-1:0]       mask;
    logic                      is_true;
    logic [NumVals-1:0][7:0]   vals;
  } job_t;

  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [1:0] ndig;
  } dec_t;

  function automatic logic is_num_slot(input logic [SlotW-1:0] slot);
    logic r;
    r = 1'b0;
    unique case (slot) inside
      SLOT_FV0, SLOT_FV1, SLOT_FV2, SLOT_BV0, SLOT_BV1, SLOT_BV2: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [ValIdxW-1:0] val_index(input logic [SlotW-1:0] slot);
    logic [ValIdxW-1:0] r;
    r = '0;
    unique case (slot)
      SLOT_FV0: r = 3'd0;
      SLOT_FV1: r = 3'd1;
      SLOT_FV2: r = 3'd2;
      SLOT_BV0: r = 3'd3;
      SLOT_BV1: r = 3'd4;
      SLOT_BV2: r = 3'd5;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] slot_char(input logic [SlotW-1:0] slot, input logic is_true);
    logic [7:0] c;
    c = CHAR_ZERO;
    unique case (slot) inside
      SLOT_ESC: c = CHAR_ESC;
      SLOT_LBR: c = 8'h5B;
      SLOT_F3:  c = 8'h33;
      SLOT_B4:  c = 8'h34;
      SLOT_F8, SLOT_B8: c = 8'h38;
      SLOT_F25, SLOT_B25: c = is_true ? 8'h32 : 8'h35;
      SLOT_FS0, SLOT_FS1, SLOT_FS2, SLOT_FS3, SLOT_MID,
      SLOT_BS0, SLOT_BS1, SLOT_BS2, SLOT_BS3: c = 8'h3B;
      SLOT_END: c = 8'h6D;
      default:  c = CHAR_ZERO;
    endcase
    return c;
  endfunction

  // Split an 8-bit value into decimal digits without a divider.
  function automatic dec_t to_dec(input logic [7:0] v);
    dec_t       d;
    logic [7:0] r;
    logic [14:0] prod;
    d.hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - ((v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0));
    // r < 100 here, so r*205 >> 11 is exactly r / 10
    prod = 15'(r[6:0]) * 15'd205;
    d.tens = prod[14:11];
    d.ones = 4'(r - 8'({d.tens, 3'd0}) - 8'({d.tens, 1'd0}));
    d.ndig = (v >= 8'd100) ? 2'd3 : ((v >= 8'd10) ? 2'd2 : 2'd1);
    return d;
  endfunction

endpackage

// File: rtl/sgr_enc_if.sv
interface sgr_enc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] fore_attr;
  logic [31:0] back_attr;

  modport source (output valid, output fore_attr, output back_attr, input ready);
  modport sink   (input valid, input fore_attr, input back_attr, output ready);
endinterface

interface sgr_enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// File: rtl/sgr_enc_front.sv
module sgr_enc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_wdata,
  input  logic                     in_valid,
  input  logic [31:0]              in_fore_attr,
  input  logic [31:0]              in_back_attr,
  input  logic                     q_full,
  output logic                     in_ready,
  output logic                     push,
  output sgr_enc_pkg::job_t        push_job
);

  logic [2:0]  mode_r;
  logic [31:0] prev_fore_r;
  logic [31:0] prev_back_r;

  logic       fire;
  logic       same;
  logic       is_true;
  logic       is_norm;
  logic [7:0] fc;
  logic [7:0] bc;
  logic       fnz;
  logic       bnz;
  logic       emit;

  // hold off transfers while in reset
  assign in_ready = rst_n && !q_full;
  assign fire     = in_valid && in_ready;
  assign same     = (in_fore_attr == prev_fore_r) && (in_back_attr == prev_back_r);

  always_comb begin
    is_true = 1'b0;
    is_norm = 1'b0;
    fc      = in_fore_attr[7:0];
    bc      = in_back_attr[7:0];
    unique case (mode_r)
      sgr_enc_pkg::MODE_TRUE: begin
        is_true = 1'b1;
      end
      sgr_enc_pkg::MODE_256: begin
        fc = in_fore_attr[7:0];
        bc = in_back_attr[7:0];
      end
      sgr_enc_pkg::MODE_216: begin
        fc = ((in_fore_attr[7:0] > 8'd215) ? 8'd7 : in_fore_attr[7:0]) + 8'h10;
        bc = ((in_back_attr[7:0] > 8'd215) ? 8'd0 : in_back_attr[7:0]) + 8'h10;
      end
      sgr_enc_pkg::MODE_GRAY: begin
        fc = ((in_fore_attr[7:0] > 8'd23) ? 8'd23 : in_fore_attr[7:0]) + 8'hE8;
        bc = ((in_back_attr[7:0] > 8'd23) ? 8'd0 : in_back_attr[7:0]) + 8'hE8;
      end
      default: begin
        is_norm = 1'b1;
        fc = {4'd0, in_fore_attr[3:0]};
        bc = {4'd0, in_back_attr[3:0]};
      end
    endcase
  end

  assign fnz  = is_true || (fc != 8'd0);
  assign bnz  = is_true || (bc != 8'd0);
  assign emit = fnz || bnz;
  assign push = fire && !same && emit;

  always_comb begin
    push_job         = '0;
    push_job.is_true = is_true;
    push_job.mask[sgr_enc_pkg::SLOT_ESC] = 1'b1;
    push_job.mask[sgr_enc_pkg::SLOT_LBR] = 1'b1;
    push_job.mask[sgr_enc_pkg::SLOT_END] = 1'b1;
    push_job.mask[sgr_enc_pkg::SLOT_F3]  = fnz;
    push_job.mask[sgr_enc_pkg::SLOT_F8]  = fnz && !is_norm;
    push_job.mask[sgr_enc_pkg::SLOT_FS0] = fnz && !is_norm;
    push_job.mask[sgr_enc_pkg::SLOT_F25] = fnz && !is_norm;
    push_job.mask[sgr_enc_pkg::SLOT_FS1] = fnz && !is_norm;
    push_job.mask[sgr_enc_pkg::SLOT_FV0] = fnz;
    push_job.mask[sgr_enc_pkg::SLOT_FS2] = is_true;
    push_job.mask[sgr_enc_pkg::SLOT_FV1] = is_true;
    push_job.mask[sgr_enc_pkg::SLOT_FS3] = is_true;
    push_job.mask[sgr_enc_pkg::SLOT_FV2] = is_true;
    push_job.mask[sgr_enc_pkg::SLOT_MID] = is_true || (fnz && bnz);
    push_job.mask[sgr_enc_pkg::SLOT_B4]  = bnz;
    push_job.mask[sgr_enc_pkg::SLOT_B8]  = bnz && !is_norm;
    push_job.mask[sgr_enc_pkg::SLOT_BS0] = bnz && !is_norm;
    push_job.mask[sgr_enc_pkg::SLOT_B25] = bnz && !is_norm;
    push_job.mask[sgr_enc_pkg::SLOT_BS1] = bnz && !is_norm;
    push_job.mask[sgr_enc_pkg::SLOT_BV0] = bnz;
    push_job.mask[sgr_enc_pkg::SLOT_BS2] = is_true;
    push_job.mask[sgr_enc_pkg::SLOT_BV1] = is_true;
    push_job.mask[sgr_enc_pkg::SLOT_BS3] = is_true;
    push_job.mask[sgr_enc_pkg::SLOT_BV2] = is_true;
    if (is_true) begin
      push_job.vals[0] = in_fore_attr[23:16];
      push_job.vals[1] = in_fore_attr[15:8];
      push_job.vals[2] = in_fore_attr[7:0];
      push_job.vals[3] = in_back_attr[23:16];
      push_job.vals[4] = in_back_attr[15:8];
      push_job.vals[5] = in_back_attr[7:0];
    end else if (is_norm) begin
      // normal mode writes the color index minus one
      push_job.vals[0] = fc - 8'd1;
      push_job.vals[3] = bc - 8'd1;
    end else begin
      push_job.vals[0] = fc;
      push_job.vals[3] = bc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= sgr_enc_pkg::MODE_NORMAL;
      prev_fore_r <= 32'hFFFF_FFFF;
      prev_back_r <= 32'hFFFF_FFFF;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      // remember the pair even when it produces no bytes
      if (fire) begin
        prev_fore_r <= in_fore_attr;
        prev_back_r <= in_back_attr;
      end
    end
  end

endmodule

// File: rtl/sgr_enc_queue.sv
module sgr_enc_queue #(
  parameter int Depth = sgr_enc_pkg::QueueDepth
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  sgr_enc_pkg::job_t        push_job,
  output logic                     full,
  output logic                     pop_valid,
  output sgr_enc_pkg::job_t        pop_job,
  input  logic                     pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sgr_enc_pkg::job_t mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [CntW-1:0]   cnt_r;

  assign full      = (cnt_r == CntW'(Depth));
  assign pop_valid = (cnt_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < CntW'(Depth)))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue read while empty");
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) |-> (cnt_r == '0 || cnt_r == CntW'(Depth)))
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: rtl/sgr_enc_back.sv
module sgr_enc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  sgr_enc_pkg::job_t        q_job,
  output logic                     q_pop,
  sgr_enc_out_if.source            out_ch
);

  sgr_enc_pkg::job_t                  job_r;
  logic                               busy_r;
  logic [sgr_enc_pkg::SlotW-1:0]      slot_r;
  logic [1:0]                         dig_r;
  logic                               out_valid_r;
  logic [7:0]                         out_byte_r;
  logic                               out_last_r;

  logic                               is_num;
  logic [7:0]                         val;
  sgr_enc_pkg::dec_t                  dec;
  logic [1:0]                         pos;
  logic [3:0]                         digit;
  logic [7:0]                         cur_byte;
  logic                               slot_done;
  logic [sgr_enc_pkg::SlotW-1:0]      nxt_slot;
  logic                               emit;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  assign q_pop = !busy_r && q_valid;
  assign emit  = busy_r && (!out_valid_r || out_ch.ready);

  assign is_num = sgr_enc_pkg::is_num_slot(slot_r);
  assign val    = job_r.vals[sgr_enc_pkg::val_index(slot_r)];
  assign dec    = sgr_enc_pkg::to_dec(val);
  // digit position counted from the ones place
  assign pos    = dec.ndig - 2'd1 - dig_r;

  always_comb begin
    case (pos)
      2'd2:    digit = {2'd0, dec.hund};
      2'd1:    digit = dec.tens;
      default: digit = dec.ones;
    endcase
  end

  assign cur_byte  = is_num ? (sgr_enc_pkg::CHAR_ZERO + {4'd0, digit})
                            : sgr_enc_pkg::slot_char(slot_r, job_r.is_true);
  assign slot_done = !is_num || (dig_r == dec.ndig - 2'd1);

  // lowest enabled slot after the current one
  always_comb begin
    nxt_slot = sgr_enc_pkg::SLOT_END;
    for (int i = sgr_enc_pkg::NumSlots - 1; i >= 0; i--) begin
      if (job_r.mask[i] && (i > int'(slot_r))) begin
        nxt_slot = sgr_enc_pkg::SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (emit) begin
      out_byte_r <= cur_byte;
      out_last_r <= (slot_r == sgr_enc_pkg::SLOT_END);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= sgr_enc_pkg::SLOT_ESC;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        slot_r <= sgr_enc_pkg::SLOT_ESC;
        dig_r  <= '0;
      end else if (emit) begin
        if (slot_done) begin
          dig_r <= '0;
          if (slot_r == sgr_enc_pkg::SLOT_END) begin
            busy_r <= 1'b0;
          end else begin
            slot_r <= nxt_slot;
          end
        end else begin
          dig_r <= dig_r + 2'd1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_slot_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> job_r.mask[slot_r])
    else $error("sequencer on a disabled slot");
  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (dig_r < dec.ndig))
    else $error("digit index past number length");
  a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && slot_r == sgr_enc_pkg::SLOT_END) |=> (!busy_r && out_last_r))
    else $error("final byte did not close the sequence");
`endif

endmodule

// File: rtl/ansi_color_sgr_encoder.sv
// ANSI SGR color encoder. Each transfer on in_ch carries a foreground and a
// background attribute; a pair equal to the previous one yields nothing, as
// does a pair whose mapped colors are both zero outside truecolor mode;
// otherwise the color escape sequence for the mode in cfg_wdata (written
// with cfg_we while idle) leaves on out_ch one byte per transfer, with
// last_byte set on the final byte. An item that yields bytes sends from 5
// bytes (a normal-mode sequence) to 36 bytes (a truecolor sequence), paced
// by the single-byte output register; an item that yields nothing never
// enters the queue. A queue of QUEUE_DEPTH classified items sits between
// input and output, so in_ch.ready stays high until that queue is full.
module ansi_color_sgr_encoder #(
  parameter int QUEUE_DEPTH = sgr_enc_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata,
  sgr_enc_in_if.sink         in_ch,
  sgr_enc_out_if.source      out_ch
);

  logic              q_full;
  logic              push;
  sgr_enc_pkg::job_t push_job;
  logic              q_valid;
  sgr_enc_pkg::job_t q_job;
  logic              q_pop;

  sgr_enc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_ch.valid),
    .in_fore_attr (in_ch.fore_attr),
    .in_back_attr (in_ch.back_attr),
    .q_full       (q_full),
    .in_ready     (in_ch.ready),
    .push         (push),
    .push_job     (push_job)
  );

  sgr_enc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .pop       (q_pop)
  );

  sgr_enc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
